FILE: hw/rtl/rhsl_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Shared widths and the sideband type that rides along the divider row.
// ----------------------------------------------------------------------------
package rhsl_pkg;

    // Field widths of the pixel and of the result word.
    localparam int CH_W    = 8;
    localparam int HUE_W   = 15;
    localparam int SAT_W   = 16;
    localparam int LIGHT_W = 9;

    // Saturation keeps 16 fractional bits, so its dividend is d shifted by 16.
    localparam int SAT_FRAC  = 16;
    localparam int SAT_DVD_W = CH_W + SAT_FRAC;

    // The hue numerator times 60 stays below 6 * 255 * 60, which needs 17 bits.
    localparam int NUM_W      = 11;
    localparam int HUE_PROD_W = 17;

    // Per-pixel data that travels with the division steps unchanged.
    typedef struct packed {
        logic [LIGHT_W-1:0] sum;   // max plus min channel
        logic               grey;  // max equals min
    } t_side;

endpackage

FILE: hw/rtl/rhsl_front.sv
// ----------------------------------------------------------------------------
// RGB to HSL front end
// Finds the largest and smallest channel and sets up both divisions.
// ----------------------------------------------------------------------------
module rhsl_front #(
    parameter int HUE_FRAC_BITS = 6,
    parameter int W             = 24
) (
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output rhsl_pkg::t_side    o_side,
    output logic [7:0]         o_sat_dvsr,
    output logic [W-1:0]       o_sat_dvd,
    output logic [7:0]         o_hue_dvsr,
    output logic [W-1:0]       o_hue_dvd
);

    logic                             red_max;
    logic                             green_max;
    logic [7:0]                       mx;
    logic [7:0]                       mn;
    logic [8:0]                       sum;
    logic [7:0]                       d;
    logic [rhsl_pkg::NUM_W-1:0]       num;
    logic [rhsl_pkg::HUE_PROD_W-1:0]  prod;

    // Sector choice: red wins ties, then green, then blue.
    always_comb begin
        red_max   = (i_red >= i_green) && (i_red >= i_blue);
        green_max = (i_green >= i_blue);
        if (red_max) begin
            mx = i_red;
        end else if (green_max) begin
            mx = i_green;
        end else begin
            mx = i_blue;
        end
        if ((i_red <= i_green) && (i_red <= i_blue)) begin
            mn = i_red;
        end else if (i_green <= i_blue) begin
            mn = i_green;
        end else begin
            mn = i_blue;
        end
        sum = {1'b0, mx} + {1'b0, mn};
        d   = mx - mn;
    end

    // Hue numerator in units of d: offset/60 * d plus the signed difference.
    // The total is never negative, so modular arithmetic on 11 bits is exact.
    always_comb begin
        if (red_max) begin
            if (i_green >= i_blue) begin
                num = {3'b000, i_green} - {3'b000, i_blue};
            end else begin
                num = {1'b0, d, 2'b00} + {2'b00, d, 1'b0}
                      - ({3'b000, i_blue} - {3'b000, i_green});
            end
        end else if (green_max) begin
            num = {2'b00, d, 1'b0} + {3'b000, i_blue} - {3'b000, i_red};
        end else begin
            num = {1'b0, d, 2'b00} + {3'b000, i_red} - {3'b000, i_green};
        end
        // Times 60 as 64 minus 4.
        prod = {num, 6'b000000} - {4'b0000, num, 2'b00};
    end

    // Divider operands: the saturation divisor folds at half lightness.
    always_comb begin
        o_side.sum  = sum;
        o_side.grey = (d == 8'd0);
        if (sum <= 9'd255) begin
            o_sat_dvsr = sum[7:0];
        end else begin
            o_sat_dvsr = 8'(9'd510 - sum);
        end
        o_sat_dvd  = W'({d, {rhsl_pkg::SAT_FRAC{1'b0}}});
        o_hue_dvsr = d;
        o_hue_dvd  = W'(prod) << HUE_FRAC_BITS;
    end

endmodule

FILE: hw/rtl/rhsl_cell.sv
// ----------------------------------------------------------------------------
// RGB to HSL divider cell
// One restoring division step for the saturation and the hue lane.
// ----------------------------------------------------------------------------
module rhsl_cell #(
    parameter int W = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rhsl_pkg::t_side    i_side,
    input  logic [7:0]         i_sat_dvsr,
    input  logic [7:0]         i_sat_rem,
    input  logic [W-1:0]       i_sat_dq,
    input  logic [7:0]         i_hue_dvsr,
    input  logic [7:0]         i_hue_rem,
    input  logic [W-1:0]       i_hue_dq,
    output logic               o_valid,
    output rhsl_pkg::t_side    o_side,
    output logic [7:0]         o_sat_dvsr,
    output logic [7:0]         o_sat_rem,
    output logic [W-1:0]       o_sat_dq,
    output logic [7:0]         o_hue_dvsr,
    output logic [7:0]         o_hue_rem,
    output logic [W-1:0]       o_hue_dq
);

    logic               r_valid;
    rhsl_pkg::t_side    r_side;
    logic [7:0]         r_sat_dvsr;
    logic [7:0]         r_sat_rem;
    logic [W-1:0]       r_sat_dq;
    logic [7:0]         r_hue_dvsr;
    logic [7:0]         r_hue_rem;
    logic [W-1:0]       r_hue_dq;

    logic [8:0]         sat_trial;
    logic [8:0]         hue_trial;
    logic               sat_ge;
    logic               hue_ge;
    logic [7:0]         n_sat_rem;
    logic [7:0]         n_hue_rem;

    // Bring down the next dividend bit and subtract the divisor if it fits.
    // The dividend leaves the top of dq while quotient bits enter at the bottom.
    always_comb begin
        sat_trial = {i_sat_rem, i_sat_dq[W-1]};
        hue_trial = {i_hue_rem, i_hue_dq[W-1]};
        sat_ge    = (sat_trial >= {1'b0, i_sat_dvsr});
        hue_ge    = (hue_trial >= {1'b0, i_hue_dvsr});
        n_sat_rem = sat_ge ? 8'(sat_trial - {1'b0, i_sat_dvsr}) : sat_trial[7:0];
        n_hue_rem = hue_ge ? 8'(hue_trial - {1'b0, i_hue_dvsr}) : hue_trial[7:0];
    end

    // Word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload moves whenever the cell can take a word.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side     <= i_side;
            r_sat_dvsr <= i_sat_dvsr;
            r_sat_rem  <= n_sat_rem;
            r_sat_dq   <= {i_sat_dq[W-2:0], sat_ge};
            r_hue_dvsr <= i_hue_dvsr;
            r_hue_rem  <= n_hue_rem;
            r_hue_dq   <= {i_hue_dq[W-2:0], hue_ge};
        end
    end

    assign o_valid    = r_valid;
    assign o_side     = r_side;
    assign o_sat_dvsr = r_sat_dvsr;
    assign o_sat_rem  = r_sat_rem;
    assign o_sat_dq   = r_sat_dq;
    assign o_hue_dvsr = r_hue_dvsr;
    assign o_hue_rem  = r_hue_rem;
    assign o_hue_dq   = r_hue_dq;

endmodule

FILE: hw/rtl/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per clock, while the output is not stalled, into hue, saturation and lightness.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and delivers one result word per pixel,
// in order. N is the larger of 24 and 17 + HUE_FRAC_BITS: one setup stage
// finds the largest and smallest channel, then a row of N divider cells
// produces one quotient bit of saturation and hue per cell. When the output
// is stalled, empty slots in the row still close up, so the input keeps
// accepting until the row is full. Lightness is max plus min (510 means 1.0),
// saturation is a 16-bit fraction clamped at 65535, and hue is degrees times
// 2^HUE_FRAC_BITS in the low 15 bits.
module rgb_to_hsl_converter #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // hue [14:0], saturation [30:15],
                                        // lightness_twice [39:31]
);

    localparam int HUE_DVD_W = rhsl_pkg::HUE_PROD_W + HUE_FRAC_BITS;
    localparam int N = (rhsl_pkg::SAT_DVD_W > HUE_DVD_W) ? rhsl_pkg::SAT_DVD_W : HUE_DVD_W;

    logic                  en    [0:N];
    logic                  valid [0:N];
    rhsl_pkg::t_side       side  [0:N];
    logic [7:0]            sat_dvsr [0:N];
    logic [7:0]            sat_rem  [0:N];
    logic [N-1:0]          sat_dq   [0:N];
    logic [7:0]            hue_dvsr [0:N];
    logic [7:0]            hue_rem  [0:N];
    logic [N-1:0]          hue_dq   [0:N];

    rhsl_pkg::t_side       n_side;
    logic [7:0]            n_sat_dvsr;
    logic [N-1:0]          n_sat_dvd;
    logic [7:0]            n_hue_dvsr;
    logic [N-1:0]          n_hue_dvd;

    logic                  r_valid;
    rhsl_pkg::t_side       r_side;
    logic [7:0]            r_sat_dvsr;
    logic [N-1:0]          r_sat_dvd;
    logic [7:0]            r_hue_dvsr;
    logic [N-1:0]          r_hue_dvd;

    logic [rhsl_pkg::HUE_W-1:0]   hue;
    logic [rhsl_pkg::SAT_W-1:0]   sat;

    // Setup logic on the incoming pixel.
    rhsl_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .W             (N)
    ) u_front (
        .i_red      (s_axis_tdata[7:0]),
        .i_green    (s_axis_tdata[15:8]),
        .i_blue     (s_axis_tdata[23:16]),
        .o_side     (n_side),
        .o_sat_dvsr (n_sat_dvsr),
        .o_sat_dvd  (n_sat_dvd),
        .o_hue_dvsr (n_hue_dvsr),
        .o_hue_dvd  (n_hue_dvd)
    );

    // A stage can load when it is empty or the stage after it moves on.
    assign en[N] = !valid[N] || m_axis_tready;
    for (genvar k = 0; k < N; k++) begin : g_en
        assign en[k] = !valid[k] || en[k+1];
    end
    assign s_axis_tready = en[0];

    // Setup stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en[0]) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side     <= n_side;
            r_sat_dvsr <= n_sat_dvsr;
            r_sat_dvd  <= n_sat_dvd;
            r_hue_dvsr <= n_hue_dvsr;
            r_hue_dvd  <= n_hue_dvd;
        end
    end

    // Both remainders start at zero.
    assign valid[0]    = r_valid;
    assign side[0]     = r_side;
    assign sat_dvsr[0] = r_sat_dvsr;
    assign sat_rem[0]  = 8'd0;
    assign sat_dq[0]   = r_sat_dvd;
    assign hue_dvsr[0] = r_hue_dvsr;
    assign hue_rem[0]  = 8'd0;
    assign hue_dq[0]   = r_hue_dvd;

    // Row of divider cells, one quotient bit per cell.
    for (genvar k = 1; k <= N; k++) begin : g_cell
        rhsl_cell #(
            .W (N)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en[k]),
            .i_valid    (valid[k-1]),
            .i_side     (side[k-1]),
            .i_sat_dvsr (sat_dvsr[k-1]),
            .i_sat_rem  (sat_rem[k-1]),
            .i_sat_dq   (sat_dq[k-1]),
            .i_hue_dvsr (hue_dvsr[k-1]),
            .i_hue_rem  (hue_rem[k-1]),
            .i_hue_dq   (hue_dq[k-1]),
            .o_valid    (valid[k]),
            .o_side     (side[k]),
            .o_sat_dvsr (sat_dvsr[k]),
            .o_sat_rem  (sat_rem[k]),
            .o_sat_dq   (sat_dq[k]),
            .o_hue_dvsr (hue_dvsr[k]),
            .o_hue_rem  (hue_rem[k]),
            .o_hue_dq   (hue_dq[k])
        );
    end

    // Grey pixels report zero hue and saturation; a full quotient clamps.
    always_comb begin
        if (side[N].grey) begin
            hue = '0;
            sat = '0;
        end else begin
            hue = hue_dq[N][rhsl_pkg::HUE_W-1:0];
            if (sat_dq[N][rhsl_pkg::SAT_FRAC]) begin
                sat = '1;
            end else begin
                sat = sat_dq[N][rhsl_pkg::SAT_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = valid[N];
    assign m_axis_tdata  = {side[N].sum, sat, hue};

endmodule

FILE: hw/rtl/rhsl_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rhsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Lightness never exceeds twice the full channel value.
    a_light: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:31] <= 9'd510)
        else $error("lightness out of range");

    // Zero saturation only comes from a grey pixel, which has no hue and
    // whose lightness is twice one channel, so even.
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[30:15] == 16'd0)
            |-> (m_axis_tdata[14:0] == 15'd0) && !m_axis_tdata[31])
        else $error("grey pixel with hue or odd lightness");

    // Black and white are grey.
    a_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tdata[39:31] == 9'd0) || (m_axis_tdata[39:31] == 9'd510))
            |-> (m_axis_tdata[30:15] == 16'd0))
        else $error("black or white pixel with saturation");

endmodule

bind rgb_to_hsl_converter rhsl_checker u_rhsl_checker (.*);

FILE: tb/tb_rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// Testbench for the RGB to HSL converter
// Streams pixels into the converter and checks each result word against a
// local fixed-point model of hue, saturation and lightness. Corner pixels
// come first, then random streams with gaps on the input side, gaps on the
// output side, full rate, and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_converter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_FRAC_BITS = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    // One converted pixel, split into its result fields.
    typedef struct packed {
        logic [rhsl_pkg::HUE_W-1:0]   hue;
        logic [rhsl_pkg::SAT_W-1:0]   sat;
        logic [rhsl_pkg::LIGHT_W-1:0] light;
    } t_hsl;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // hue [14:0], saturation [30:15],
                                       // lightness_twice [39:31]

    t_hsl hsl_expected_q[$];
    int   mismatch_cnt  = 0;
    int   pixels_sent   = 0;
    int   results_seen  = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_seq      = 0;

    rgb_to_hsl_converter #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Expected hue, saturation and lightness of one pixel, in exact integer math.
    function automatic t_hsl convert_pixel(input logic [rhsl_pkg::CH_W-1:0] r, g, b);
        int unsigned rv, gv, bv, hi, lo, sum, d, den, num, q, hue_v, sat_v;
        t_hsl res;
        rv = r;
        gv = g;
        bv = b;
        hi = (rv > gv) ? rv : gv;
        hi = (hi > bv) ? hi : bv;
        lo = (rv < gv) ? rv : gv;
        lo = (lo < bv) ? lo : bv;
        sum = hi + lo;
        d = hi - lo;
        hue_v = 0;
        sat_v = 0;
        // A grey pixel keeps hue and saturation at zero.
        if (d != 0) begin
            den = (sum <= 255) ? sum : 510 - sum;
            q = (d << rhsl_pkg::SAT_FRAC) / den;
            sat_v = (q > 65535) ? 65535 : q;
            // Red wins ties, then green; the red sector wraps to 360 when green < blue.
            if (hi == rv) begin
                num = (gv >= bv) ? gv - bv : 6 * d - (bv - gv);
            end else if (hi == gv) begin
                num = 2 * d + bv - rv;
            end else begin
                num = 4 * d + rv - gv;
            end
            hue_v = ((num * 60) << HUE_FRAC_BITS) / d;
        end
        res.hue = hue_v[rhsl_pkg::HUE_W-1:0];
        res.sat = sat_v[rhsl_pkg::SAT_W-1:0];
        res.light = sum[rhsl_pkg::LIGHT_W-1:0];
        return res;
    endfunction

    // Offer one pixel, with random idle cycles ahead of it, and wait until taken.
    task automatic send_pixel(input logic [rhsl_pkg::CH_W-1:0] r, g, b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, g, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hsl_expected_q.push_back(convert_pixel(r, g, b));
        pixels_sent++;
    endtask

    // Random pixel, biased toward greys, tied channels and extreme values.
    task automatic rand_pixel(output logic [rhsl_pkg::CH_W-1:0] r, g, b);
        logic [rhsl_pkg::CH_W-1:0] a, c;
        int                        kind;
        kind = $urandom_range(9);
        a = 8'($urandom_range(255));
        c = 8'($urandom_range(255));
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
        case (kind)
            0: begin
                r = a;
                g = a;
                b = a;
            end
            1: begin
                case ($urandom_range(2))
                    0: begin r = c; g = a; b = a; end
                    1: begin r = a; g = c; b = a; end
                    default: begin r = a; g = a; b = c; end
                endcase
            end
            2: begin
                r = $urandom_range(1) ? 8'(255 - $urandom_range(1)) : 8'($urandom_range(1));
                g = $urandom_range(1) ? 8'(255 - $urandom_range(1)) : 8'($urandom_range(1));
                b = $urandom_range(1) ? 8'(255 - $urandom_range(1)) : 8'($urandom_range(1));
            end
            default: ;
        endcase
    endtask

    task automatic run_random_pixels(input int count);
        logic [rhsl_pkg::CH_W-1:0] r, g, b;
        repeat (count) begin
            rand_pixel(r, g, b);
            send_pixel(r, g, b);
        end
    endtask

    // Black, white, greys, primaries, ties, the hue wrap and full saturation.
    task automatic test_directed_corners();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd200, 8'd10, 8'd11);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd2, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd127, 8'd128, 8'd128);
        send_pixel(8'd200, 8'd100, 8'd57);
        send_pixel(8'd57, 8'd200, 8'd100);
        send_pixel(8'd100, 8'd57, 8'd200);
        send_pixel(8'd254, 8'd1, 8'd255);
        send_pixel(8'd170, 8'd85, 8'd85);
    endtask

    task automatic test_stream_sender_gaps();
        send_idle_pct = 34;
        recv_idle_pct = 71;
        run_random_pixels(410);
    endtask

    task automatic test_stream_receiver_gaps();
        send_idle_pct = 71;
        recv_idle_pct = 34;
        run_random_pixels(410);
    endtask

    task automatic test_stream_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_pixels(300);
    endtask

    // The output holds off for a long stretch while pixels keep coming.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq++;
        run_random_pixels(120);
    endtask

    // Output side: random ready, plus a long hold whenever one is requested.
    always @(posedge i_clk) begin
        int hold_left;
        int hold_seen;
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // Each result word is compared with the oldest outstanding pixel.
    always @(posedge i_clk) begin
        t_hsl exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (hsl_expected_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatch_cnt++;
            end else begin
                exp_w = hsl_expected_q.pop_front();
                check_field("hue", 32'(exp_w.hue), 32'(m_axis_tdata[rhsl_pkg::HUE_W-1:0]));
                check_field("saturation", 32'(exp_w.sat),
                            32'(m_axis_tdata[rhsl_pkg::HUE_W +: rhsl_pkg::SAT_W]));
                check_field("lightness_twice", 32'(exp_w.light),
                            32'(m_axis_tdata[rhsl_pkg::HUE_W+rhsl_pkg::SAT_W +:
                                             rhsl_pkg::LIGHT_W]));
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 34;
        recv_idle_pct = 71;
        test_directed_corners();
        test_stream_sender_gaps();
        test_stream_receiver_gaps();
        test_stream_full_rate();
        test_output_backpressure();
        s_axis_tvalid <= 1'b0;
        while (hsl_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Converted %0d pixels: corners, greys, tied channels, extremes and random.",
                 pixels_sent);
        $display("Gaps on each side, full rate and a long output stall; %0d words checked.",
                 results_seen);
        if (mismatch_cnt == 0) begin
            $display("PASS rgb_to_hsl_converter");
        end else begin
            $display("FAIL rgb_to_hsl_converter");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAIL rgb_to_hsl_converter");
        $finish;
    end

endmodule
